// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Same-cycle and next-cycle implication checks, sampled on the rising edge
// and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the cycle in which ante holds
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// cons must hold in the cycle after ante holds
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/det_pkg.sv =====
// ----------------------------------------------------------------------------
// det_pkg
// Types and codes of the directory entry table: beat layouts, the stored
// entry layout, operation and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package det_pkg;

	localparam int ENTRY_COUNT_W = 7;

	// operation codes
	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_UPDATE = 3'd2;
	localparam logic [2:0] OP_DELETE = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [63:0] name_key;
		logic [23:0] extension;
		logic [31:0] cluster_in;
		logic [31:0] new_size;
	} in_item_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [31:0]              cluster_out;
		logic [31:0]              size_out;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} out_item_t;

	// one stored directory entry
	typedef struct packed {
		logic [63:0] name;
		logic [23:0] ext;
		logic [31:0] cluster;
		logic [31:0] size;
	} entry_t;

endpackage

// ===== rtl/det_ram.sv =====
// ----------------------------------------------------------------------------
// det_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module det_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/directory_entry_table_top.sv =====
// ----------------------------------------------------------------------------
// directory_entry_table_top
// Ordered directory table keyed by an 8-byte file name, searched linearly.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats (in_valid/in_ready/in_data) carry an operation: add, lookup,
//   update size, delete or clear. Every request yields one response beat
//   (out_valid/out_ready/out_data) with status, cluster, size and the entry
//   count after the operation. in_ready is high only while the sequencer is
//   idle, so one request is worked on at a time.
//   Steps from request accept to response valid:
//     add, clear, unused codes: the result goes straight to the done state.
//     lookup, update: the search runs until a hit or the end of the table;
//     it walks the entry RAM one entry per cycle
//     through its single read port and one name compare.
//     delete: the same search, then later entries are moved down (none
//     for the last entry), one read and one write of the entry RAM per
//     cycle.
//   The next request can be taken in the cycle in which the response goes
//   valid.
//   A stalled receiver holds the response in the output register; the next
//   result then waits in the sequencer with in_ready low until out_ready frees
//   it. Reset empties the table at once (count only, no sweep).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module directory_entry_table_top import det_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = $bits(entry_t);

	// sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_SHIFT  = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] wk_q;
	logic          chk_q;
	logic [2:0]    op_q;
	logic [63:0]   key_q;
	logic [31:0]   nsz_q;
	out_item_t     res_q;
	out_item_t     out_q;
	logic          out_valid_q;

	logic          in_fire;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_raw;
	entry_t        rd_entry;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;
	logic          hit;
	logic [AW-1:0] hit_pos;
	logic          not_full;
	logic          res_load;
	out_item_t     start_res;
	logic [CW-1:0] start_count;
	logic [1:0]    start_state;
	logic          shift_wr;
	logic          full_done;
	logic          search_req;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign not_full  = (count_q < CW'(MAX_ENTRIES));

	// read side: walk entries below the count
	assign rd_en    = ((state_q == S_SEARCH) || (state_q == S_SHIFT)) && (idx_q < count_q);
	assign rd_addr  = idx_q[AW-1:0];
	assign rd_entry = entry_t'(rd_raw);

	// name compare on the entry read last cycle
	assign hit     = (state_q == S_SEARCH) && chk_q && (rd_entry.name == key_q);
	assign hit_pos = AW'(idx_q - CW'(1));

	// result handoff into the output register
	assign res_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// write port select: append, size update or move-down
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = count_q[AW-1:0];
		wr_entry = rd_entry;
		if (in_fire && (in_data.operation == OP_ADD) && not_full) begin
			wr_en            = 1'b1;
			wr_entry.name    = in_data.name_key;
			wr_entry.ext     = in_data.extension;
			wr_entry.cluster = in_data.cluster_in;
			wr_entry.size    = '0;
		end else if (hit && (op_q == OP_UPDATE)) begin
			wr_en         = 1'b1;
			wr_addr       = hit_pos;
			wr_entry.size = nsz_q;
		end else if ((state_q == S_SHIFT) && chk_q) begin
			wr_en   = 1'b1;
			wr_addr = wk_q;
		end
	end

	det_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTRIES)
	) u_entries (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(EW'(wr_entry)),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	// request decode at accept
	always_comb begin
		start_res             = '0;
		start_res.status      = ST_OK;
		start_res.entry_count = ENTRY_COUNT_W'(count_q);
		start_count           = count_q;
		start_state           = S_DONE;
		case (in_data.operation)
			OP_ADD: begin
				if (not_full) begin
					start_count           = count_q + CW'(1);
					start_res.entry_count = ENTRY_COUNT_W'(count_q + CW'(1));
				end else begin
					start_res.status = ST_FULL;
				end
			end
			OP_LOOKUP, OP_UPDATE, OP_DELETE: begin
				start_state = S_SEARCH;
			end
			OP_CLEAR: begin
				start_count           = '0;
				start_res.entry_count = '0;
			end
			default: begin
				// unused codes leave the table alone
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			wk_q    <= '0;
			chk_q   <= 1'b0;
			op_q    <= OP_ADD;
			key_q   <= '0;
			nsz_q   <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						op_q    <= in_data.operation;
						key_q   <= in_data.name_key;
						nsz_q   <= in_data.new_size;
						idx_q   <= '0;
						chk_q   <= 1'b0;
						res_q   <= start_res;
						count_q <= start_count;
						state_q <= start_state;
					end
				end
				S_SEARCH: begin
					if (hit) begin
						res_q <= '{status: ST_OK,
							cluster_out: rd_entry.cluster,
							size_out: (op_q == OP_UPDATE) ? nsz_q : rd_entry.size,
							entry_count: ENTRY_COUNT_W'(count_q)};
						chk_q <= 1'b0;
						if (op_q == OP_DELETE) begin
							// idx_q already points at the entry after the match
							wk_q    <= hit_pos;
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_DONE;
						end
					end else if (!chk_q && (idx_q >= count_q)) begin
						res_q <= '{status: ST_NOT_FOUND, cluster_out: '0, size_out: '0,
							entry_count: ENTRY_COUNT_W'(count_q)};
						state_q <= S_DONE;
					end else begin
						chk_q <= rd_en;
						if (rd_en) begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				S_SHIFT: begin
					chk_q <= rd_en;
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end
					if (chk_q) begin
						wk_q <= wk_q + AW'(1);
					end
					if (!chk_q && (idx_q >= count_q)) begin
						count_q           <= count_q - CW'(1);
						res_q.entry_count <= ENTRY_COUNT_W'(count_q - CW'(1));
						state_q           <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_q       <= res_q;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// checks
	assign shift_wr   = wr_en && (state_q == S_SHIFT);
	assign full_done  = (state_q == S_DONE) && (res_q.status == ST_FULL);
	assign search_req = in_fire &&
		((in_data.operation == OP_LOOKUP) || (in_data.operation == OP_DELETE));

	`ASSERT_IMPLIES(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(MAX_ENTRIES))
	`ASSERT_IMPLIES(a_shift_below_count, clk, arst_n, shift_wr, (CW'(wk_q) + CW'(1)) < idx_q)
	`ASSERT_IMPLIES(a_full_status, clk, arst_n, full_done, count_q == CW'(MAX_ENTRIES))
	`ASSERT_NEXT(a_search_starts, clk, arst_n, search_req, (state_q == S_SEARCH) && !chk_q)

endmodule
